// ----- rtl/core/x86_real_mode_subset_core_defines.svh -----
// Assertion helpers for the core; x86rm_exec is the only file that includes them.
`ifndef X86_REAL_MODE_SUBSET_CORE_DEFINES_SVH
`define X86_REAL_MODE_SUBSET_CORE_DEFINES_SVH

`define X86RM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`define X86RM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/x86rm_pkg.sv -----
package x86rm_pkg;

  localparam int unsigned LinAddrBits = 20;
  localparam int unsigned RamBytesBits = 21;

  localparam logic [15:0] FlCf = 16'h0001;
  localparam logic [15:0] FlZf = 16'h0040;
  localparam logic [15:0] FlSf = 16'h0080;
  localparam logic [15:0] FlIf = 16'h0200;
  localparam logic [15:0] FlReset = 16'h0002;
  localparam logic [15:0] SpReset = 16'h7c00;
  localparam logic [15:0] BootIp = 16'h7c00;
  localparam logic [10:0] KibMax = 11'd1024;

  localparam logic [2:0] RegAx = 3'd0;
  localparam logic [2:0] RegDx = 3'd2;
  localparam logic [2:0] RegSp = 3'd4;
  localparam logic [1:0] SegCs = 2'd1;
  localparam logic [1:0] SegSs = 2'd2;

  localparam logic [7:0] OpAddAl = 8'h04;
  localparam logic [7:0] OpSubAl = 8'h2c;
  localparam logic [7:0] OpXor = 8'h31;
  localparam logic [7:0] OpMovRr = 8'h89;
  localparam logic [7:0] OpInImm = 8'he4;
  localparam logic [7:0] OpOutImm = 8'he6;
  localparam logic [7:0] IntVideo = 8'h10;
  localparam logic [7:0] IntMemSize = 8'h12;
  localparam logic [7:0] IntBoot = 8'h19;
  localparam logic [7:0] TtyFunc = 8'h0e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HALTED  = 2'd1,
    ST_ERROR   = 2'd2,
    ST_REFUSED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    IO_NONE  = 2'd0,
    IO_READ  = 2'd1,
    IO_WRITE = 2'd2,
    IO_CONS  = 2'd3
  } io_e;

  typedef enum logic [4:0] {
    CL_MOV16, CL_MOV8, CL_PUSH, CL_POP, CL_INCDEC, CL_NOP, CL_HLT, CL_CLI,
    CL_STI, CL_INT, CL_JMPS, CL_JMPN, CL_JCC, CL_ALU, CL_IN, CL_OUT,
    CL_MODRM, CL_BAD, CL_IRQ
  } class_e;

  typedef struct packed {
    class_e      cls;
    logic [7:0]  opcode;
    logic [7:0]  operand_lo;
    logic [7:0]  operand_hi;
    logic [15:0] stack_word;
    logic [15:0] vector_ip;
    logic [15:0] vector_cs;
    logic [7:0]  io_read_data;
    logic        io_read_ok;
    logic [7:0]  irq_vector;
  } q_item_t;

  typedef struct packed {
    logic [1:0]             mask;
    logic [LinAddrBits-1:0] addr;
    logic [15:0]            data;
  } wr_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] next_ip;
    logic [15:0] code_seg;
    logic [15:0] stack_ptr;
    logic [15:0] stack_seg;
    io_e         io_action;
    logic [15:0] io_port;
    logic [7:0]  byte_out;
  } res_t;

  function automatic logic [LinAddrBits-1:0] lin_addr(logic [15:0] seg, logic [15:0] off);
    logic [LinAddrBits-1:0] s;
    s = {seg, 4'b0000} + {4'b0000, off};
    return s;
  endfunction

  function automatic logic [1:0] wr_mask(logic [LinAddrBits-1:0] a,
                                         logic [RamBytesBits-1:0] rb);
    logic [RamBytesBits-1:0] ax;
    ax = {1'b0, a};
    return {((ax + 21'd1) < rb), (ax < rb)};
  endfunction

endpackage

// ----- rtl/core/x86rm_if.sv -----
interface x86rm_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  opcode;
  logic [7:0]  operand_lo;
  logic [7:0]  operand_hi;
  logic [15:0] stack_word;
  logic [15:0] vector_ip;
  logic [15:0] vector_cs;
  logic [7:0]  io_read_data;
  logic        io_read_ok;
  logic [7:0]  irq_vector;
  modport source (output valid, kind, opcode, operand_lo, operand_hi, stack_word, vector_ip,
                  vector_cs, io_read_data, io_read_ok, irq_vector, input ready);
  modport sink (input valid, kind, opcode, operand_lo, operand_hi, stack_word, vector_ip,
                vector_cs, io_read_data, io_read_ok, irq_vector, output ready);
endinterface

interface x86rm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] next_ip;
  logic [15:0] code_seg;
  logic [15:0] stack_ptr;
  logic [15:0] stack_seg;
  logic [1:0]  mem_write_mask;
  logic [19:0] mem_write_addr;
  logic [15:0] mem_write_data;
  logic [1:0]  io_action;
  logic [15:0] io_port;
  logic [7:0]  byte_out;
  logic        last;
  modport source (output valid, status, next_ip, code_seg, stack_ptr, stack_seg,
                  mem_write_mask, mem_write_addr, mem_write_data, io_action, io_port,
                  byte_out, last, input ready);
  modport sink (input valid, status, next_ip, code_seg, stack_ptr, stack_seg,
                mem_write_mask, mem_write_addr, mem_write_data, io_action, io_port,
                byte_out, last, output ready);
endinterface

// ----- rtl/core/x86rm_front.sv -----
module x86rm_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  x86rm_in_if.sink          in_i,
  output logic              q_valid_o,
  output x86rm_pkg::q_item_t q_item_o,
  input  logic              q_pop_i
);
  import x86rm_pkg::*;

  q_item_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  class_e     cls;

  always_comb begin
    cls = CL_BAD;
    if (in_i.kind) begin
      cls = CL_IRQ;
    end else begin
      unique case (in_i.opcode) inside
        [8'hb8:8'hbf]:        cls = CL_MOV16;
        [8'hb0:8'hb7]:        cls = CL_MOV8;
        [8'h50:8'h57]:        cls = CL_PUSH;
        [8'h58:8'h5f]:        cls = CL_POP;
        [8'h40:8'h4f]:        cls = CL_INCDEC;
        8'h90:                cls = CL_NOP;
        8'hf4:                cls = CL_HLT;
        8'hfa:                cls = CL_CLI;
        8'hfb:                cls = CL_STI;
        8'hcd:                cls = CL_INT;
        8'heb:                cls = CL_JMPS;
        8'he9:                cls = CL_JMPN;
        8'h74, 8'h75:         cls = CL_JCC;
        8'h3c, 8'h2c, 8'h04:  cls = CL_ALU;
        8'he4, 8'hec:         cls = CL_IN;
        8'he6, 8'hee:         cls = CL_OUT;
        8'h31, 8'h89, 8'h8e:  cls = CL_MODRM;
        default:              cls = CL_BAD;
      endcase
    end
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push = in_i.valid && in_i.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{cls: cls, opcode: in_i.opcode, operand_lo: in_i.operand_lo,
                           operand_hi: in_i.operand_hi, stack_word: in_i.stack_word,
                           vector_ip: in_i.vector_ip, vector_cs: in_i.vector_cs,
                           io_read_data: in_i.io_read_data, io_read_ok: in_i.io_read_ok,
                           irq_vector: in_i.irq_vector};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

endmodule

// ----- rtl/core/x86rm_exec.sv -----
module x86rm_exec (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [10:0]        cfg_wdata_i,
  input  logic               q_valid_i,
  input  x86rm_pkg::q_item_t q_item_i,
  output logic               q_pop_o,
  x86rm_out_if.source        out_o
);
  import x86rm_pkg::*;
  `include "x86_real_mode_subset_core_defines.svh"

  logic [15:0] gr_q [8];
  logic [15:0] gr_d [8];
  logic [15:0] sg_q [4];
  logic [15:0] sg_d [4];
  logic [15:0] ip_q, ip_d, fl_q, fl_d;
  logic        halt_q, halt_d;
  logic [10:0] kib_q, kib;
  logic [RamBytesBits-1:0] rb;

  logic [1:0] cnt_q;
  res_t       res_q, res;
  wr_t        slot_q [3];
  wr_t        w [3];
  logic [1:0] nres;

  logic [7:0]  op, b1, al, ar;
  logic [15:0] imm, sp, sp1, sp2, sp3, sx, v, pv, rr;
  logic [2:0]  src, dst;
  logic [LinAddrBits-1:0] pa;
  logic [RamBytesBits-1:0] paw;
  logic [10:0] ivt;
  logic        take, car;

  assign kib = (kib_q == 11'd0 || kib_q > KibMax) ? KibMax : kib_q;
  assign rb = {kib[9:0] == 10'd0 ? kib : kib, 10'b0} ;
  assign op = q_item_i.opcode;
  assign b1 = q_item_i.operand_lo;
  assign imm = {q_item_i.operand_hi, b1};
  assign sp = gr_q[RegSp];
  assign sp1 = sp - 16'd2;
  assign sp2 = sp - 16'd4;
  assign sp3 = sp - 16'd6;
  assign sx = {{8{b1[7]}}, b1};
  assign al = gr_q[RegAx][7:0];
  assign src = b1[5:3];
  assign dst = b1[2:0];
  assign pa = lin_addr(sg_q[SegSs], sp);
  assign paw = {1'b0, pa};
  assign ivt = {1'b0, q_item_i.irq_vector, 2'b00};
  assign q_pop_o = q_valid_i && (cnt_q == 2'd0 || (cnt_q == 2'd1 && out_o.ready));

  always_comb begin
    gr_d = gr_q;
    sg_d = sg_q;
    ip_d = ip_q;
    fl_d = fl_q;
    halt_d = halt_q;
    res = '0;
    res.status = ST_OK;
    res.io_action = IO_NONE;
    w[0] = '0;
    w[1] = '0;
    w[2] = '0;
    nres = 2'd1;
    v = '0;
    pv = '0;
    rr = '0;
    ar = '0;
    take = 1'b0;
    car = 1'b0;
    if (q_item_i.cls == CL_IRQ) begin
      if (!fl_q[9] || ({10'b0, ivt} + 21'd3) >= rb) begin
        res.status = ST_REFUSED;
      end else begin
        nres = 2'd3;
        w[0] = '{mask: wr_mask(lin_addr(sg_q[SegSs], sp1), rb),
                 addr: lin_addr(sg_q[SegSs], sp1), data: fl_q};
        w[1] = '{mask: wr_mask(lin_addr(sg_q[SegSs], sp2), rb),
                 addr: lin_addr(sg_q[SegSs], sp2), data: sg_q[SegCs]};
        w[2] = '{mask: wr_mask(lin_addr(sg_q[SegSs], sp3), rb),
                 addr: lin_addr(sg_q[SegSs], sp3), data: ip_q};
        gr_d[RegSp] = sp3;
        fl_d = fl_q & ~FlIf;
        ip_d = q_item_i.vector_ip;
        sg_d[SegCs] = q_item_i.vector_cs;
        halt_d = 1'b0;
      end
    end else if (halt_q) begin
      res.status = ST_HALTED;
    end else begin
      ip_d = ip_q + 16'd1;
      unique case (q_item_i.cls)
        CL_MOV16: begin
          gr_d[op[2:0]] = imm;
          ip_d = ip_q + 16'd3;
        end
        CL_MOV8: begin
          if (op[2]) gr_d[{1'b0, op[1:0]}][15:8] = b1;
          else gr_d[{1'b0, op[1:0]}][7:0] = b1;
          ip_d = ip_q + 16'd2;
        end
        CL_PUSH: begin
          gr_d[RegSp] = sp1;
          w[0] = '{mask: wr_mask(lin_addr(sg_q[SegSs], sp1), rb),
                   addr: lin_addr(sg_q[SegSs], sp1), data: gr_q[op[2:0]]};
        end
        CL_POP: begin
          pv = q_item_i.stack_word;
          if (paw >= rb) pv[7:0] = 8'hff;
          if ((paw + 21'd1) >= rb) pv[15:8] = 8'hff;
          gr_d[RegSp] = sp + 16'd2;
          gr_d[op[2:0]] = pv;
        end
        CL_INCDEC: begin
          v = op[3] ? gr_q[op[2:0]] - 16'd1 : gr_q[op[2:0]] + 16'd1;
          gr_d[op[2:0]] = v;
          fl_d = (fl_q & ~FlZf) | ((v == 16'd0) ? FlZf : 16'd0);
        end
        CL_NOP: begin
        end
        CL_HLT: begin
          halt_d = 1'b1;
          res.status = ST_HALTED;
        end
        CL_CLI: fl_d = fl_q & ~FlIf;
        CL_STI: fl_d = fl_q | FlIf;
        CL_INT: begin
          ip_d = ip_q + 16'd2;
          if (b1 == IntVideo && gr_q[RegAx][15:8] == TtyFunc) begin
            res.io_action = IO_CONS;
            res.byte_out = al;
          end else if (b1 == IntMemSize) begin
            gr_d[RegAx] = {5'b0, kib};
          end else if (b1 == IntBoot) begin
            sg_d[SegCs] = '0;
            ip_d = BootIp;
          end else begin
            res.status = ST_ERROR;
          end
        end
        CL_JMPS: ip_d = ip_q + 16'd2 + sx;
        CL_JMPN: ip_d = ip_q + 16'd3 + imm;
        CL_JCC: begin
          take = (fl_q[6] == ~op[0]);
          ip_d = ip_q + 16'd2 + (take ? sx : 16'd0);
        end
        CL_ALU: begin
          ip_d = ip_q + 16'd2;
          if (op == OpAddAl) begin
            {car, ar} = {1'b0, al} + {1'b0, b1};
          end else begin
            ar = al - b1;
            car = (al < b1);
          end
          if (op == OpAddAl || op == OpSubAl) gr_d[RegAx][7:0] = ar;
          fl_d = (fl_q & ~(FlZf | FlSf | FlCf)) | ((ar == 8'd0) ? FlZf : 16'd0) |
                 (ar[7] ? FlSf : 16'd0) | (car ? FlCf : 16'd0);
        end
        CL_IN, CL_OUT: begin
          if (op == OpInImm || op == OpOutImm) begin
            ip_d = ip_q + 16'd2;
            res.io_port = {8'd0, b1};
          end else begin
            res.io_port = gr_q[RegDx];
          end
          if (q_item_i.cls == CL_IN) begin
            res.io_action = IO_READ;
            gr_d[RegAx][7:0] = q_item_i.io_read_ok ? q_item_i.io_read_data : 8'hff;
          end else begin
            res.io_action = IO_WRITE;
            res.byte_out = al;
          end
        end
        CL_MODRM: begin
          ip_d = ip_q + 16'd2;
          if (b1[7:6] != 2'b11) begin
            res.status = ST_ERROR;
          end else if (op == OpXor) begin
            rr = gr_q[dst] ^ gr_q[src];
            gr_d[dst] = rr;
            fl_d = (fl_q & ~(FlZf | FlSf | FlCf)) | ((rr == 16'd0) ? FlZf : 16'd0) |
                   (rr[15] ? FlSf : 16'd0);
          end else if (op == OpMovRr) begin
            gr_d[dst] = gr_q[src];
          end else if (src[1:0] == SegCs) begin
            res.status = ST_ERROR;
          end else begin
            sg_d[src[1:0]] = gr_q[dst];
          end
        end
        default: res.status = ST_ERROR;
      endcase
    end
    res.next_ip = ip_d;
    res.code_seg = sg_d[SegCs];
    res.stack_ptr = gr_d[RegSp];
    res.stack_seg = sg_d[SegSs];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) gr_q[i] <= '0;
      gr_q[RegSp] <= SpReset;
      for (int i = 0; i < 4; i++) sg_q[i] <= '0;
      ip_q   <= '0;
      fl_q   <= FlReset;
      halt_q <= 1'b0;
      kib_q  <= KibMax;
      cnt_q  <= 2'd0;
    end else begin
      if (cfg_we_i) kib_q <= cfg_wdata_i;
      if (q_pop_o) begin
        gr_q   <= gr_d;
        sg_q   <= sg_d;
        ip_q   <= ip_d;
        fl_q   <= fl_d;
        halt_q <= halt_d;
        cnt_q  <= nres;
      end else if (out_o.valid && out_o.ready) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= res;
      slot_q <= w;
    end else if (out_o.valid && out_o.ready) begin
      slot_q[0] <= slot_q[1];
      slot_q[1] <= slot_q[2];
    end
  end

  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.last = (cnt_q == 2'd1);
  assign out_o.status = res_q.status;
  assign out_o.next_ip = res_q.next_ip;
  assign out_o.code_seg = res_q.code_seg;
  assign out_o.stack_ptr = res_q.stack_ptr;
  assign out_o.stack_seg = res_q.stack_seg;
  assign out_o.io_action = res_q.io_action;
  assign out_o.io_port = res_q.io_port;
  assign out_o.byte_out = res_q.byte_out;
  assign out_o.mem_write_mask = slot_q[0].mask;
  assign out_o.mem_write_addr = slot_q[0].addr;
  assign out_o.mem_write_data = slot_q[0].data;

  `X86RM_ASSERT_NEXT(a_multi_hold, out_o.valid && !out_o.last, out_o.valid, "results dropped")
  `X86RM_ASSERT_IMPL(a_pop_space, q_pop_o, cnt_q == 2'd0 || (cnt_q == 2'd1 && out_o.ready), "pop without room")
  `X86RM_ASSERT_IMPL(a_refused_single, out_o.valid && out_o.status == ST_REFUSED, out_o.last, "refused item not single")

endmodule

// ----- rtl/core/x86_real_mode_subset_core.sv -----
// An accepted item waits in the queue; once popped, its result is registered in the
// result stage. One instruction per cycle while the output is ready; an accepted
// interrupt holds the result stage until all three of its stack writes are sent.
// A two-entry queue separates the decode side from the execute side.
// Reset is asynchronous and active low; registers and memory size return to their
// power-on values, and both queue and result stage empty.
module x86_real_mode_subset_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  x86rm_in_if.sink    in_i,
  x86rm_out_if.source out_o
);
  import x86rm_pkg::*;

  logic    q_valid, q_pop;
  q_item_t q_item;

  x86rm_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  x86rm_exec u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_o       (out_o)
  );

endmodule
